### sv/qpd_pkg.sv
// Shared constants, types and helpers for the quoted-printable decoder.
package qpd_pkg;

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_US = 8'h5F;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  // escape phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_EQ    = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_SOFT  = 2'd3;

  localparam int QUEUE_DEPTH_DEF = 2;

  // One decoded item's worth of results: up to three bytes, low byte first.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  cnt;       // number of results, 1 to 3
    logic        has_byte;  // 0 only for a bare end marker
    logic        last;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) v = c - 8'h30;
    else if ((c >= 8'h41) && (c <= 8'h46)) v = c - 8'h37;
    else if ((c >= 8'h61) && (c <= 8'h66)) v = c - 8'h57;
    return v[3:0];
  endfunction

endpackage

### sv/quoted_printable_decoder_unit.sv
// Quoted-printable / Q-encoding decoder: one encoded byte in, 0 to 3 bytes out.
// Each byte's results are registered in the job queue before they reach the output.
// Throughput: one input beat per cycle while each byte gives at most one result and
// out_stall is low; a byte giving several results holds the result sequencer until all
// its beats are sent, the job queue (QUEUE_DEPTH entries) absorbing the difference. Synchronous active-low reset
// clears escape state, mode (quoted-printable) and the queue.
module quoted_printable_decoder_unit #(
  parameter int QUEUE_DEPTH = qpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_last
);
  import qpd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t head_job;

  assign in_stall = q_full;

  qpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  qpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  qpd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (q_not_empty),
    .job          (head_job),
    .job_pop      (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

endmodule

### sv/qpd_front.sv
// Front end: accepts encoded bytes, tracks the escape state, builds result jobs.
module qpd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          q_full,
  output logic          q_push,
  output qpd_pkg::job_t q_job
);
  import qpd_pkg::*;

  logic        mode_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [1:0]  n;
  logic [23:0] res;
  logic        do_ord;
  logic        accept;

  assign accept = in_valid && !q_full;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    n         = 2'd0;
    res       = 24'd0;
    do_ord    = 1'b0;

    case (phase_r)
      PH_EQ: begin
        phase_nxt = PH_IDLE;
        if (!mode_r && (in_byte == CH_CR)) begin
          phase_nxt = PH_SOFT;
        end else if (!mode_r && (in_byte == CH_LF)) begin
          phase_nxt = PH_IDLE;  // soft break, nothing out
        end else if (is_hex(in_byte)) begin
          held_nxt  = in_byte;
          phase_nxt = PH_DIGIT;
        end else begin
          res[{n, 3'b000} +: 8] = CH_EQ;
          n = n + 2'd1;
          do_ord = 1'b1;
        end
      end
      PH_DIGIT: begin
        phase_nxt = PH_IDLE;
        if (is_hex(in_byte)) begin
          res[{n, 3'b000} +: 8] = {hex_val(held_r), hex_val(in_byte)};
          n = n + 2'd1;
        end else begin
          res[{n, 3'b000} +: 8] = CH_EQ;
          n = n + 2'd1;
          res[{n, 3'b000} +: 8] = held_r;
          n = n + 2'd1;
          do_ord = 1'b1;
        end
      end
      PH_SOFT: begin
        phase_nxt = PH_IDLE;
        do_ord = (in_byte != CH_LF);
      end
      default: begin
        do_ord = 1'b1;
      end
    endcase

    if (do_ord) begin
      if (in_byte == CH_EQ) begin
        phase_nxt = PH_EQ;
      end else begin
        res[{n, 3'b000} +: 8] = (mode_r && (in_byte == CH_US)) ? CH_SP : in_byte;
        n = n + 2'd1;
      end
    end

    // end of text flushes a pending escape
    if (in_last) begin
      if (phase_nxt == PH_EQ) begin
        res[{n, 3'b000} +: 8] = CH_EQ;
        n = n + 2'd1;
      end else if (phase_nxt == PH_DIGIT) begin
        res[{n, 3'b000} +: 8] = CH_EQ;
        n = n + 2'd1;
        res[{n, 3'b000} +: 8] = held_nxt;
        n = n + 2'd1;
      end
      phase_nxt = PH_IDLE;
    end
  end

  assign q_push         = accept && ((n != 2'd0) || in_last);
  assign q_job.bytes    = res;
  assign q_job.cnt      = (n == 2'd0) ? 2'd1 : n;
  assign q_job.has_byte = (n != 2'd0);
  assign q_job.last     = in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule

### sv/qpd_queue.sv
// Short job queue between the front end and the result sequencer.
module qpd_queue #(
  parameter int DEPTH = qpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  qpd_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output qpd_pkg::job_t head
);
  import qpd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
  end

endmodule

### sv/qpd_back.sv
// Back end: walks the head job and sends one result beat per cycle while out_stall is low.
module qpd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  qpd_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_has_byte,
  output logic          out_last
);
  import qpd_pkg::*;

  logic [1:0] idx_r;
  logic       final_beat;
  logic       beat;

  assign final_beat   = (idx_r == (job.cnt - 2'd1));
  assign beat         = job_valid && !out_stall;
  assign job_pop      = beat && final_beat;

  assign out_valid    = job_valid;
  assign out_byte     = job.bytes[{idx_r, 3'b000} +: 8];
  assign out_has_byte = job.has_byte;
  assign out_last     = job.last && final_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (beat) begin
      idx_r <= final_beat ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

### verif/quoted_printable_decoder_unit_tb.sv
// Self-checking testbench for the quoted-printable / Q-encoding decoder unit.
`timescale 1ns / 1ps

module quoted_printable_decoder_unit_tb;
  import qpd_pkg::*;

  localparam int RANDOM_BEATS   = 100;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT        = 45;   // output beat count that starts the long hold
  localparam int HOLD_LEN       = 60;

  typedef enum logic {MODE_QP = 1'b0, MODE_Q = 1'b1} mode_e;
  typedef enum logic {ROW_BYTE = 1'b0, ROW_MODE = 1'b1} row_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } dec_beat_t;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] data;   // byte, or the new mode in bit 0
    logic       fin;
    logic       typed;  // expected beat given below instead of predicted
    logic [7:0] xdata;
    logic       xhas;
    logic       xfin;
  } script_row_t;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte     = 8'h00;
  logic       in_last     = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_last;

  // decoder shadow state
  logic       mode_q  = MODE_QP;
  logic [1:0] phase_q = PH_IDLE;
  logic [7:0] held_q  = 8'h00;
  int         burst;

  dec_beat_t   decoded_q[$];
  script_row_t script[$];
  logic [7:0]  text_q[$];

  dec_beat_t want;
  int  errors       = 0;
  int  beats_in     = 0;
  int  beats_out    = 0;
  int  mode_writes  = 0;
  int  quiet_cycles = 0;
  int  hold_left    = 0;
  bit  held_once    = 1'b0;
  bit  gaps_on      = 1'b1;

  quoted_printable_decoder_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // {valid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  function automatic void emit(input logic [7:0] b);
    decoded_q.push_back({b, 1'b1, 1'b0});
    burst++;
  endfunction

  function automatic void plain_byte(input logic [7:0] c);
    if (c == CH_EQ) phase_q = PH_EQ;
    else if (c == CH_US && mode_q) emit(CH_SP);
    else emit(c);
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic fin);
    logic [4:0] nib;
    logic [4:0] hi;
    dec_beat_t  tail;
    nib   = hex_nibble(c);
    hi    = hex_nibble(held_q);
    burst = 0;
    case (phase_q)
      PH_EQ: begin
        phase_q = PH_IDLE;
        if (!mode_q && c == CH_CR) begin
          phase_q = PH_SOFT;
        end else if (!mode_q && c == CH_LF) begin
          // soft break, nothing out
        end else if (nib[4]) begin
          held_q  = c;
          phase_q = PH_DIGIT;
        end else begin
          emit(CH_EQ);
          plain_byte(c);
        end
      end
      PH_DIGIT: begin
        phase_q = PH_IDLE;
        if (nib[4]) begin
          emit({hi[3:0], nib[3:0]});
        end else begin
          emit(CH_EQ);
          emit(held_q);
          plain_byte(c);
        end
      end
      PH_SOFT: begin
        phase_q = PH_IDLE;
        if (c != CH_LF) plain_byte(c);
      end
      default: plain_byte(c);
    endcase
    if (fin) begin
      if (phase_q == PH_EQ) begin
        emit(CH_EQ);
      end else if (phase_q == PH_DIGIT) begin
        emit(CH_EQ);
        emit(held_q);
      end
      phase_q = PH_IDLE;
      if (burst == 0) begin
        decoded_q.push_back({8'h00, 1'b0, 1'b1});
        burst = 1;
      end else begin
        tail     = decoded_q.pop_back();
        tail.fin = 1'b1;
        decoded_q.push_back(tail);
      end
    end
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic fin);
    while (gaps_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (in_stall);
    decode_byte(b, fin);
    beats_in++;
  endtask

  // stop offering, wait for every expected beat, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_e m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_q = m;
    mode_writes++;
  endtask

  task automatic add_row(input row_kind_e kind, input logic [7:0] data, input logic fin,
                         input logic typed, input logic [7:0] xdata, input logic xhas);
    script.push_back({kind, data, fin, typed, xdata, xhas, fin});
  endtask

  task automatic add_token();
    int         pick;
    logic [7:0] c;
    logic [4:0] nib;
    pick = $urandom_range(99);
    if (pick < 35) begin
      text_q.push_back(8'($urandom_range(8'h7E, 8'h20)));
    end else if (pick < 55) begin
      text_q.push_back(CH_EQ);
      text_q.push_back(hex_char(4'($urandom), 1'($urandom)));
      text_q.push_back(hex_char(4'($urandom), 1'($urandom)));
    end else if (pick < 63) begin
      text_q.push_back(CH_EQ);
      case ($urandom_range(2))
        0: begin
          text_q.push_back(CH_CR);
          text_q.push_back(CH_LF);
        end
        1: text_q.push_back(CH_CR);
        default: text_q.push_back(CH_LF);
      endcase
    end else if (pick < 70) begin
      text_q.push_back(CH_US);
    end else if (pick < 78) begin
      // broken escape
      text_q.push_back(CH_EQ);
      if ($urandom_range(1)) text_q.push_back(hex_char(4'($urandom), 1'($urandom)));
      do begin
        c   = 8'($urandom);
        nib = hex_nibble(c);
      end while (nib[4]);
      text_q.push_back(c);
    end else if (pick < 86) begin
      text_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
    end else begin
      text_q.push_back(8'($urandom));
    end
  endtask

  // result side: checker plus random and long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got byte=%h has=%b last=%b",
                   $time, out_byte, out_has_byte, out_last);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data || out_has_byte !== want.has || out_last !== want.fin) begin
            errors++;
            $display("%0t: mismatch, expected byte=%h has=%b last=%b, got byte=%h has=%b last=%b",
                     $time, want.data, want.has, want.fin, out_byte, out_has_byte, out_last);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && beats_out >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 29);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[quoted_printable_decoder_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    dec_beat_t typed_beat;
    int        text_no;
    int        stop_at;

    // quoted-printable mode out of reset
    add_row(ROW_BYTE, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1);
    add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1);
    add_row(ROW_BYTE, CH_US, 1'b1, 1'b1, CH_US, 1'b1);
    add_row(ROW_BYTE, CH_EQ, 1'b1, 1'b1, CH_EQ, 1'b1);   // lone equals cut by the end
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, "a",   1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, "F",   1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);   // equals, digit, non-hex
    add_row(ROW_BYTE, "3",   1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, "Z",   1'b1, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);   // CR LF soft break
    add_row(ROW_BYTE, CH_CR, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_LF, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, "x",   1'b1, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);   // LF soft break leaves an empty end
    add_row(ROW_BYTE, CH_LF, 1'b1, 1'b1, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);   // held digit cut by the end
    add_row(ROW_BYTE, "7",   1'b1, 1'b0, 8'h00, 1'b0);
    // Q mode: underscore is space, CR after equals is not a break
    add_row(ROW_MODE, 8'(MODE_Q), 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_US, 1'b0, 1'b1, CH_SP, 1'b1);
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_CR, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_US, 1'b1, 1'b0, 8'h00, 1'b0);
    // mode flipped while a CR soft break is pending: LF still swallowed
    add_row(ROW_MODE, 8'(MODE_QP), 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_CR, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_MODE, 8'(MODE_Q), 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_LF, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, "k",   1'b1, 1'b0, 8'h00, 1'b0);
    // equals seen in Q mode, LF decoded after switching back
    add_row(ROW_BYTE, CH_EQ, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_MODE, 8'(MODE_QP), 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, CH_LF, 1'b1, 1'b1, 8'h00, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_MODE) begin
        write_mode(mode_e'(script[i].data[0]));
      end else begin
        send_beat(script[i].data, script[i].fin);
        if (script[i].typed) begin
          repeat (burst) void'(decoded_q.pop_back());
          typed_beat = {script[i].xdata, script[i].xhas, script[i].xfin};
          decoded_q.push_back(typed_beat);
        end
      end
    end

    stop_at = beats_in + RANDOM_BEATS;
    text_no = 0;
    while (beats_in < stop_at) begin
      gaps_on = !(text_no >= 6 && text_no < 14);
      if (text_no == 4) drain();
      else if ($urandom_range(99) < 20) write_mode(mode_e'($urandom_range(1)));
      text_q.delete();
      repeat ($urandom_range(6, 1)) add_token();
      foreach (text_q[i]) begin
        if ($urandom_range(99) < 3) write_mode(mode_e'($urandom_range(1)));
        send_beat(text_q[i], i == text_q.size() - 1);
      end
      text_no++;
    end

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d encoded bytes, %0d decoded beats, %0d mode writes, %0d texts random",
             beats_in, beats_out, mode_writes, text_no);
    $display("Covered hex escapes, soft breaks, broken and cut escapes, both modes, long stall");
    if (errors == 0) begin
      $display("[quoted_printable_decoder_unit] OK");
    end else begin
      $display("[quoted_printable_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
